>>> src/clipped_gray_glyph_blit_top_defines.svh
// assertion helpers shared by the glyph blit modules
`ifndef CLIPPED_GRAY_GLYPH_BLIT_TOP_DEFINES_SVH
`define CLIPPED_GRAY_GLYPH_BLIT_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define CGB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define CGB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/cgb_pkg.sv
package cgb_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 13;
    localparam int AddrWidth     = 25;

    // register indexes of the configuration port
    localparam logic [CfgIndexWidth-1:0] CFG_GLYPH_WIDTH   = 3'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_GLYPH_HEIGHT  = 3'd1;
    localparam logic [CfgIndexWidth-1:0] CFG_ORIGIN_X      = 3'd2;
    localparam logic [CfgIndexWidth-1:0] CFG_ORIGIN_Y      = 3'd3;
    localparam logic [CfgIndexWidth-1:0] CFG_SCREEN_WIDTH  = 3'd4;
    localparam logic [CfgIndexWidth-1:0] CFG_SCREEN_HEIGHT = 3'd5;
    localparam logic [CfgIndexWidth-1:0] CFG_LINE_PITCH    = 3'd6;

    // coverage thresholds and palette entries
    localparam logic [7:0] COV_FULL  = 8'd200;
    localparam logic [7:0] COV_HALF  = 8'd100;
    localparam logic [7:0] COV_LIGHT = 8'd40;
    localparam logic [3:0] COLOR_FULL  = 4'd15;
    localparam logic [3:0] COLOR_HALF  = 4'd7;
    localparam logic [3:0] COLOR_LIGHT = 4'd8;
    localparam logic [3:0] COLOR_NONE  = 4'd0;

    typedef struct packed {
        logic [7:0]         glyph_width;
        logic [7:0]         glyph_height;
        logic signed [12:0] origin_x;
        logic signed [12:0] origin_y;
        logic [11:0]        screen_width;
        logic [11:0]        screen_height;
        logic [12:0]        line_pitch;
    } cgb_cfg_t;

    // one accepted pixel waiting in the input stage
    typedef struct packed {
        logic       valid;
        logic [7:0] coverage;
        logic [7:0] column;
        logic [7:0] row;
        logic       last;
    } cgb_item_t;

    function automatic logic [3:0] cgb_quantize(input logic [7:0] cov);
        logic [3:0] color;
        if (cov >= COV_FULL)
            color = COLOR_FULL;
        else if (cov >= COV_HALF)
            color = COLOR_HALF;
        else if (cov >= COV_LIGHT)
            color = COLOR_LIGHT;
        else
            color = COLOR_NONE;
        return color;
    endfunction

endpackage

>>> src/clipped_gray_glyph_blit_top.sv
// Clipped gray glyph blitter: takes glyph coverage bytes in raster order, one
// request per clock while in_stall is low, and returns one pixel result per
// request - a write flag, the frame buffer byte address (row times line_pitch
// plus column) and a four-entry palette color, with glyph_done on the glyph's
// last pixel. Pixels off screen come back with write_enable low and zero
// address and color. The block sustains one pixel per clock while out_stall
// is low: a request passes an input stage (where the column and row counters
// advance) and a result stage (13x13 multiply plus column add). in_stall
// rises only while the result register is full and out_stall is high.
// Configuration writes are taken every cycle and must only happen while no
// pixel is in flight.
module clipped_gray_glyph_blit_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cgb_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [cgb_pkg::CfgDataWidth-1:0]    cfg_data,
    // coverage request channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [7:0]                          coverage,
    // pixel result channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                write_enable,
    output logic [cgb_pkg::AddrWidth-1:0]       pixel_address,
    output logic [3:0]                          palette_color,
    output logic                                glyph_done
);
    import cgb_pkg::*;

    cgb_cfg_t  cfg;
    cgb_item_t item;
    logic      advance;

    // glyph geometry, origin, screen bounds and pitch
    cgb_config_regs u_config
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // raster position counters and input stage
    cgb_raster_counter u_counter
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .coverage (coverage),
        .advance  (advance),
        .item     (item)
    );

    // clipping, address, palette lookup and result register
    cgb_pixel_stage u_pixel
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .item          (item),
        .advance       (advance),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .write_enable  (write_enable),
        .pixel_address (pixel_address),
        .palette_color (palette_color),
        .glyph_done    (glyph_done)
    );

endmodule

>>> src/cgb_config_regs.sv
module cgb_config_regs
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [cgb_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [cgb_pkg::CfgDataWidth-1:0]    cfg_data,
    output cgb_pkg::cgb_cfg_t                   cfg
);
    import cgb_pkg::*;

    cgb_cfg_t cfg_reg;
    cgb_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_GLYPH_WIDTH:   cfg_next.glyph_width   = cfg_data[7:0];
                CFG_GLYPH_HEIGHT:  cfg_next.glyph_height  = cfg_data[7:0];
                CFG_ORIGIN_X:      cfg_next.origin_x      = $signed(cfg_data);
                CFG_ORIGIN_Y:      cfg_next.origin_y      = $signed(cfg_data);
                CFG_SCREEN_WIDTH:  cfg_next.screen_width  = cfg_data[11:0];
                CFG_SCREEN_HEIGHT: cfg_next.screen_height = cfg_data[11:0];
                CFG_LINE_PITCH:    cfg_next.line_pitch    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= '0;
        else
            cfg_reg <= cfg_next;
    end

endmodule

>>> src/cgb_raster_counter.sv
`include "clipped_gray_glyph_blit_top_defines.svh"

module cgb_raster_counter
(
    input  logic                clk,
    input  logic                rst_n,
    input  cgb_pkg::cgb_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [7:0]          coverage,
    input  logic                advance,
    output cgb_pkg::cgb_item_t  item
);
    import cgb_pkg::*;

    logic [7:0] column_reg;
    logic [7:0] column_next;
    logic [7:0] row_reg;
    logic [7:0] row_next;
    cgb_item_t  item_reg;
    cgb_item_t  item_next;
    logic       accept;
    logic       row_end;
    logic       last;

    assign in_stall = item_reg.valid && !advance;
    assign accept   = in_valid && !in_stall;
    assign item     = item_reg;

    // 9-bit compares so a count of 255 still ends a row of width 0 or 255
    assign row_end = ({1'b0, column_reg} + 9'd1) >= {1'b0, cfg.glyph_width};
    assign last    = row_end && (({1'b0, row_reg} + 9'd1) >= {1'b0, cfg.glyph_height});

    always_comb
    begin
        column_next = column_reg;
        row_next    = row_reg;
        item_next   = item_reg;
        if (accept)
        begin
            item_next.valid    = 1'b1;
            item_next.coverage = coverage;
            item_next.column   = column_reg;
            item_next.row      = row_reg;
            item_next.last     = last;
            if (last)
            begin
                column_next = '0;
                row_next    = '0;
            end
            else if (row_end)
            begin
                column_next = '0;
                row_next    = row_reg + 8'd1;
            end
            else
            begin
                column_next = column_reg + 8'd1;
            end
        end
        else if (advance)
        begin
            item_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg <= '0;
            row_reg    <= '0;
            item_reg   <= '0;
        end
        else
        begin
            column_reg <= column_next;
            row_reg    <= row_next;
            item_reg   <= item_next;
        end
    end

    `CGB_ASSERT_NEXT(a_wrap_after_last, accept && last,
        column_reg == 8'd0 && row_reg == 8'd0, "counters did not wrap after last pixel")
    `CGB_ASSERT_NEXT(a_column_step, accept && !row_end,
        column_reg == $past(column_reg) + 8'd1, "column did not step")
    `CGB_ASSERT_NEXT(a_hold_when_idle, !accept,
        column_reg == $past(column_reg) && row_reg == $past(row_reg),
        "counters moved without a request")

endmodule

>>> src/cgb_pixel_stage.sv
`include "clipped_gray_glyph_blit_top_defines.svh"

module cgb_pixel_stage
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  cgb_pkg::cgb_cfg_t                   cfg,
    input  cgb_pkg::cgb_item_t                  item,
    output logic                                advance,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                write_enable,
    output logic [cgb_pkg::AddrWidth-1:0]       pixel_address,
    output logic [3:0]                          palette_color,
    output logic                                glyph_done
);
    import cgb_pkg::*;

    logic signed [13:0]   sx;
    logic signed [13:0]   sy;
    logic                 on_screen;
    logic [25:0]          row_offset;
    logic [AddrWidth-1:0] addr;
    logic                 valid_reg;
    logic                 valid_next;
    logic                 we_reg;
    logic [AddrWidth-1:0] addr_reg;
    logic [3:0]           color_reg;
    logic                 done_reg;
    logic                 load;

    function automatic logic signed [13:0] origin_ext(input logic signed [12:0] o);
        return {o[12], o};
    endfunction

    assign advance = !valid_reg || !out_stall;
    assign load    = advance && item.valid;

    // screen position, 14 bits signed covers origin plus a full glyph
    assign sx = {origin_ext(cfg.origin_x)} + $signed({6'b0, item.column});
    assign sy = {origin_ext(cfg.origin_y)} + $signed({6'b0, item.row});

    assign on_screen = !sx[13] && !sy[13]
                    && (sx[12:0] < {1'b0, cfg.screen_width})
                    && (sy[12:0] < {1'b0, cfg.screen_height});

    assign row_offset = {13'b0, sy[12:0]} * {13'b0, cfg.line_pitch};
    assign addr       = row_offset[AddrWidth-1:0] + {12'b0, sx[12:0]};

    assign valid_next = advance ? item.valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            we_reg    <= on_screen;
            addr_reg  <= on_screen ? addr : '0;
            color_reg <= on_screen ? cgb_quantize(item.coverage) : COLOR_NONE;
            done_reg  <= item.last;
        end
    end

    assign out_valid     = valid_reg;
    assign write_enable  = we_reg;
    assign pixel_address = addr_reg;
    assign palette_color = color_reg;
    assign glyph_done    = done_reg;

    `CGB_ASSERT_NOW(a_clipped_zero, valid_reg && !we_reg,
        addr_reg == '0 && color_reg == COLOR_NONE, "clipped pixel carries data")
    `CGB_ASSERT_NOW(a_palette_set, valid_reg,
        color_reg == COLOR_NONE || color_reg == COLOR_LIGHT ||
        color_reg == COLOR_HALF || color_reg == COLOR_FULL, "color outside palette")
    `CGB_ASSERT_NEXT(a_result_refill, item.valid && advance, valid_reg,
        "accepted pixel lost between stages")

endmodule
